// ===== rtl/core/imusi_pkg.sv =====
// shared types, constants and fixed-point helpers for the strapdown integrator
`timescale 1ns / 1ps
package imusi_pkg;

	typedef logic signed [15:0] accel_t;
	typedef logic signed [15:0] quat_t;
	typedef logic signed [47:0] pos_t;
	typedef logic signed [31:0] vel_t;
	typedef logic signed [17:0] wacc_t;

	// shared multiplier operands and product
	typedef logic signed [34:0] opa_t;
	typedef logic signed [32:0] opb_t;
	typedef logic signed [67:0] wide_t;

	localparam int ADDR_W = 5;

	// register map, word index
	localparam logic [2:0] REG_GRAVITY = 3'd0;
	localparam logic [2:0] REG_ACC_DB  = 3'd1;
	localparam logic [2:0] REG_VEL_DB  = 3'd2;
	localparam logic [2:0] REG_DT      = 3'd3;
	localparam logic [2:0] REG_DT_SQ   = 3'd4;

	localparam logic [11:0] GRAVITY_RST = 12'd2512;
	localparam logic [9:0]  ACC_DB_RST  = 10'd15;
	localparam logic [15:0] VEL_DB_RST  = 16'd1966;
	localparam logic [23:0] DT_RST      = 24'd167772;
	localparam logic [31:0] DT_SQ_RST   = 32'd429497;

	localparam wide_t SAT18_HI = wide_t'(64'sd131071);
	localparam wide_t SAT18_LO = wide_t'(-64'sd131072);
	localparam wide_t SAT32_HI = wide_t'(64'sd2147483647);
	localparam wide_t SAT32_LO = wide_t'(-64'sd2147483648);
	localparam wide_t SAT48_HI = wide_t'(64'sh0000_7FFF_FFFF_FFFF);
	localparam wide_t SAT48_LO = wide_t'(-64'sh0000_8000_0000_0000);

	// round half up, then arithmetic shift
	function automatic wide_t rnd(wide_t v, int unsigned n);
		return (v + (wide_t'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic wacc_t sat18(wide_t v);
		if (v > SAT18_HI) return wacc_t'(SAT18_HI[17:0]);
		else if (v < SAT18_LO) return wacc_t'(SAT18_LO[17:0]);
		else return wacc_t'(v[17:0]);
	endfunction

	function automatic vel_t sat32(wide_t v);
		if (v > SAT32_HI) return vel_t'(SAT32_HI[31:0]);
		else if (v < SAT32_LO) return vel_t'(SAT32_LO[31:0]);
		else return vel_t'(v[31:0]);
	endfunction

	function automatic pos_t sat48(wide_t v);
		if (v > SAT48_HI) return pos_t'(SAT48_HI[47:0]);
		else if (v < SAT48_LO) return pos_t'(SAT48_LO[47:0]);
		else return pos_t'(v[47:0]);
	endfunction

endpackage

// ===== rtl/core/imusi_ifs.sv =====
// sample and result channel interfaces
`timescale 1ns / 1ps
interface imusi_sample_if import imusi_pkg::*; ();
	logic   valid;
	logic   ready;
	accel_t accel_x;
	accel_t accel_y;
	accel_t accel_z;
	quat_t  quat_w;
	quat_t  quat_x;
	quat_t  quat_y;
	quat_t  quat_z;
	modport source(output valid, accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z,
		input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z,
		output ready);
endinterface

interface imusi_result_if import imusi_pkg::*; ();
	logic  valid;
	logic  ready;
	pos_t  pos_x;
	pos_t  pos_y;
	pos_t  pos_z;
	vel_t  vel_x;
	vel_t  vel_y;
	vel_t  vel_z;
	wacc_t world_acc_x;
	wacc_t world_acc_y;
	wacc_t world_acc_z;
	logic  accel_zeroed;
	logic  velocity_zeroed;
	modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, world_acc_x,
		world_acc_y, world_acc_z, accel_zeroed, velocity_zeroed, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, world_acc_x,
		world_acc_y, world_acc_z, accel_zeroed, velocity_zeroed, output ready);
endinterface

// ===== rtl/core/imusi_mul.sv =====
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module imusi_mul import imusi_pkg::*; (
	input  logic  clk,
	input  opa_t  a,
	input  opb_t  b,
	output wide_t p
);
	always_ff @(posedge clk) begin
		p <= wide_t'(a) * wide_t'(b);
	end
endmodule

// ===== rtl/core/imu_strapdown_integrator.sv =====
// strapdown dead-reckoning integrator: gravity removal, rotation, deadband zeroing, trapezoid integration
// sequence: 40 sequencer steps per sample word, 39 of them multiplies through the one shared
//   multiplier, then write-back of the result into its output register
// flow: sample.ready is high only while idle, so a new sample word is taken only after the last
//   one has been written back; a finished result may wait in its output register while the next sample loads
// reset: arst_n clears control, position, velocity and previous acceleration,
//   and loads the register defaults
`timescale 1ns / 1ps
module imu_strapdown_integrator import imusi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	imusi_sample_if.sink      sample,
	imusi_result_if.source    result
);
	typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

	// sequencer step map
	localparam logic [5:0] ST_QP  = 6'd0;   // ten quaternion products
	localparam logic [5:0] ST_M   = 6'd10;  // form rotation matrix
	localparam logic [5:0] ST_G   = 6'd11;  // gravity in body frame
	localparam logic [5:0] ST_R2  = 6'd14;  // residual length squared
	localparam logic [5:0] ST_ADB = 6'd17;  // accel deadband squared
	localparam logic [5:0] ST_S   = 6'd18;  // rotate into world
	localparam logic [5:0] ST_INT = 6'd27;  // integrate, three per axis
	localparam logic [5:0] ST_V2  = 6'd36;  // velocity length squared
	localparam logic [5:0] ST_VDB = 6'd39;  // velocity deadband squared

	state_t      state_q;
	logic [5:0]  step_q;
	logic        ph_q;

	logic [11:0] grav_q;
	logic [9:0]  adb_q;
	logic [15:0] vdb_q;
	logic [23:0] dt_q;
	logic [31:0] dtsq_q;

	accel_t            a_q [3];
	quat_t             q_q [4];
	logic signed [31:0] qp_q [10];
	opa_t              m_q [9];
	wacc_t             r_q [3];
	wacc_t             wa_q [3];
	wacc_t             prev_q [3];
	vel_t              vel_q [3];
	pos_t              pos_q [3];
	wide_t             acc_q;
	logic              azero_q;
	logic              vzero_q;

	logic              out_valid_q;
	pos_t              out_pos_q [3];
	vel_t              out_vel_q [3];
	wacc_t             out_wa_q [3];
	logic              out_az_q;
	logic              out_vz_q;

	opa_t  mul_a;
	opb_t  mul_b;
	wide_t p;

	logic  cfg_wr;
	logic  in_acc;
	logic  out_free;
	logic signed [18:0] asum [3];

	imusi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign in_acc   = sample.valid & sample.ready;
	assign out_free = ~out_valid_q | result.ready;

	assign sample.ready = (state_q == S_IDLE);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			asum[i] = 19'(wa_q[i]) + 19'(prev_q[i]);
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			6'd0: begin mul_a = opa_t'(q_q[0]); mul_b = opb_t'(q_q[0]); end
			6'd1: begin mul_a = opa_t'(q_q[1]); mul_b = opb_t'(q_q[1]); end
			6'd2: begin mul_a = opa_t'(q_q[2]); mul_b = opb_t'(q_q[2]); end
			6'd3: begin mul_a = opa_t'(q_q[3]); mul_b = opb_t'(q_q[3]); end
			6'd4: begin mul_a = opa_t'(q_q[1]); mul_b = opb_t'(q_q[2]); end
			6'd5: begin mul_a = opa_t'(q_q[0]); mul_b = opb_t'(q_q[3]); end
			6'd6: begin mul_a = opa_t'(q_q[1]); mul_b = opb_t'(q_q[3]); end
			6'd7: begin mul_a = opa_t'(q_q[0]); mul_b = opb_t'(q_q[2]); end
			6'd8: begin mul_a = opa_t'(q_q[2]); mul_b = opb_t'(q_q[3]); end
			6'd9: begin mul_a = opa_t'(q_q[0]); mul_b = opb_t'(q_q[1]); end
			default: begin
			end
		endcase
		for (int k = 0; k < 3; k++) begin
			if (step_q == 6'(ST_G + k)) begin
				mul_a = m_q[6 + k];
				mul_b = opb_t'({21'd0, grav_q});
			end
			if (step_q == 6'(ST_R2 + k)) begin
				mul_a = opa_t'(r_q[k]);
				mul_b = opb_t'(r_q[k]);
			end
			if (step_q == 6'(ST_V2 + k)) begin
				mul_a = opa_t'(vel_q[k]);
				mul_b = opb_t'(vel_q[k]);
			end
			if (step_q == 6'(ST_INT + 3 * k)) begin
				mul_a = opa_t'(asum[k]);
				mul_b = opb_t'({1'b0, dtsq_q});
			end
			if (step_q == 6'(ST_INT + 3 * k + 1)) begin
				mul_a = opa_t'(vel_q[k]);
				mul_b = opb_t'({9'd0, dt_q});
			end
			if (step_q == 6'(ST_INT + 3 * k + 2)) begin
				mul_a = opa_t'(asum[k]);
				mul_b = opb_t'({9'd0, dt_q});
			end
		end
		for (int k = 0; k < 9; k++) begin
			if (step_q == 6'(ST_S + k)) begin
				mul_a = m_q[k];
				mul_b = opb_t'(r_q[k % 3]);
			end
		end
		if (step_q == ST_ADB) begin
			mul_a = opa_t'({25'd0, adb_q});
			mul_b = opb_t'({23'd0, adb_q});
		end
		if (step_q == ST_VDB) begin
			mul_a = opa_t'({19'd0, vdb_q});
			mul_b = opb_t'({17'd0, vdb_q});
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GRAVITY_RST;
			adb_q  <= ACC_DB_RST;
			vdb_q  <= VEL_DB_RST;
			dt_q   <= DT_RST;
			dtsq_q <= DT_SQ_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_GRAVITY: grav_q <= pwdata[11:0];
				REG_ACC_DB:  adb_q  <= pwdata[9:0];
				REG_VEL_DB:  vdb_q  <= pwdata[15:0];
				REG_DT:      dt_q   <= pwdata[23:0];
				REG_DT_SQ:   dtsq_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_GRAVITY: prdata = {20'd0, grav_q};
			REG_ACC_DB:  prdata = {22'd0, adb_q};
			REG_VEL_DB:  prdata = {16'd0, vdb_q};
			REG_DT:      prdata = {8'd0, dt_q};
			REG_DT_SQ:   prdata = dtsq_q;
			default:     prdata = '0;
		endcase
	end

	// working registers, loaded per step
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q[0] <= sample.accel_x;
			a_q[1] <= sample.accel_y;
			a_q[2] <= sample.accel_z;
			q_q[0] <= sample.quat_w;
			q_q[1] <= sample.quat_x;
			q_q[2] <= sample.quat_y;
			q_q[3] <= sample.quat_z;
		end
		if (state_q == S_RUN && ph_q) begin
			for (int k = 0; k < 10; k++) begin
				if (step_q == 6'(ST_QP + k)) qp_q[k] <= p[31:0];
			end
			if (step_q == ST_M) begin
				// ww xx yy zz xy wz xz wy yz wx
				m_q[0] <= opa_t'(qp_q[0]) + opa_t'(qp_q[1]) - opa_t'(qp_q[2]) - opa_t'(qp_q[3]);
				m_q[1] <= (opa_t'(qp_q[4]) - opa_t'(qp_q[5])) <<< 1;
				m_q[2] <= (opa_t'(qp_q[6]) + opa_t'(qp_q[7])) <<< 1;
				m_q[3] <= (opa_t'(qp_q[4]) + opa_t'(qp_q[5])) <<< 1;
				m_q[4] <= opa_t'(qp_q[0]) - opa_t'(qp_q[1]) + opa_t'(qp_q[2]) - opa_t'(qp_q[3]);
				m_q[5] <= (opa_t'(qp_q[8]) - opa_t'(qp_q[9])) <<< 1;
				m_q[6] <= (opa_t'(qp_q[6]) - opa_t'(qp_q[7])) <<< 1;
				m_q[7] <= (opa_t'(qp_q[8]) + opa_t'(qp_q[9])) <<< 1;
				m_q[8] <= opa_t'(qp_q[0]) - opa_t'(qp_q[1]) - opa_t'(qp_q[2]) + opa_t'(qp_q[3]);
			end
			for (int k = 0; k < 3; k++) begin
				if (step_q == 6'(ST_G + k)) r_q[k] <= sat18(wide_t'(a_q[k]) - rnd(p, 28));
				if (step_q == 6'(ST_R2 + k)) acc_q <= (k == 0) ? p : acc_q + p;
				if (step_q == 6'(ST_V2 + k)) acc_q <= (k == 0) ? p : acc_q + p;
				if (step_q == 6'(ST_INT + 3 * k)) acc_q <= p;
			end
			if (step_q == ST_ADB) azero_q <= (acc_q < p);
			if (step_q == ST_VDB) vzero_q <= (acc_q < p);
			for (int k = 0; k < 9; k++) begin
				if (step_q == 6'(ST_S + k)) begin
					acc_q <= (k % 3 == 0) ? p : acc_q + p;
					if (k % 3 == 2) begin
						wa_q[k / 3] <= azero_q ? '0 : sat18(rnd(acc_q + p, 28));
					end
				end
			end
		end
	end

	// control, integrator state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			ph_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_az_q    <= 1'b0;
			out_vz_q    <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i]    <= '0;
				vel_q[i]     <= '0;
				pos_q[i]     <= '0;
				out_pos_q[i] <= '0;
				out_vel_q[i] <= '0;
				out_wa_q[i]  <= '0;
			end
		end else begin
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_RUN;
						step_q  <= ST_QP;
						ph_q    <= 1'b0;
					end
				end
				S_RUN: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						// previous acceleration drops out when this one is zeroed
						if (step_q == 6'(ST_S + 8) && azero_q) begin
							for (int i = 0; i < 3; i++) prev_q[i] <= '0;
						end
						for (int k = 0; k < 3; k++) begin
							if (step_q == 6'(ST_INT + 3 * k + 1)) begin
								pos_q[k] <= sat48(wide_t'(pos_q[k]) + rnd(acc_q + (p <<< 2), 26));
							end
							if (step_q == 6'(ST_INT + 3 * k + 2)) begin
								vel_q[k] <= sat32(wide_t'(vel_q[k]) + rnd(p, 17));
							end
						end
						if (step_q == ST_VDB) state_q <= S_DONE;
						else step_q <= step_q + 6'd1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						for (int i = 0; i < 3; i++) begin
							out_pos_q[i] <= pos_q[i];
							out_vel_q[i] <= vzero_q ? '0 : vel_q[i];
							out_wa_q[i]  <= wa_q[i];
							prev_q[i]    <= wa_q[i];
							if (vzero_q) vel_q[i] <= '0;
						end
						out_az_q <= azero_q;
						out_vz_q <= vzero_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid           = out_valid_q;
	assign result.pos_x           = out_pos_q[0];
	assign result.pos_y           = out_pos_q[1];
	assign result.pos_z           = out_pos_q[2];
	assign result.vel_x           = out_vel_q[0];
	assign result.vel_y           = out_vel_q[1];
	assign result.vel_z           = out_vel_q[2];
	assign result.world_acc_x     = out_wa_q[0];
	assign result.world_acc_y     = out_wa_q[1];
	assign result.world_acc_z     = out_wa_q[2];
	assign result.accel_zeroed    = out_az_q;
	assign result.velocity_zeroed = out_vz_q;

endmodule

// ===== rtl/core/imusi_checker.sv =====
// port-level checks for the strapdown integrator, bound to the top level
`timescale 1ns / 1ps
module imusi_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic pready
);
	// an accepted sample word takes ready low and keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready)
		else $error("ready came back too soon after a sample word");

	// a new result only appears out of a busy period
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word without work in progress");

	// stalled result word stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result word dropped while stalled");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind imu_strapdown_integrator imusi_checker u_imusi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (sample.valid),
	.in_ready (sample.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.pready   (pready)
);
